// ----- sv/hfbp_pkg.sv -----
// Package: types, constants and arithmetic helpers for the two-state HMM block.
package hfbp_pkg;

    localparam int MAX_STEPS = 1024;

    localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LN_HALF = -32'sd45426;
    localparam logic signed [31:0] LN_TWO  = 32'sd45426;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [0:0] REG_INIT0 = 1'b0;
    localparam logic [0:0] REG_INIT1 = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] emit_log_0;
        logic signed [31:0] emit_log_1;
        logic signed [31:0] trans_log_00;
        logic signed [31:0] trans_log_01;
        logic signed [31:0] trans_log_10;
        logic signed [31:0] trans_log_11;
        logic               is_last;
        logic [9:0]         read_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0] log_likelihood;
        logic [16:0]        post_0;
        logic [16:0]        post_1;
        logic               status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD1,
        ST_FWD2,
        ST_FWD3,
        ST_BWD_INIT,
        ST_BWD_RD,
        ST_BWD_A,
        ST_BWD_B,
        ST_BWD_C,
        ST_BWD_D,
        ST_POST_A,
        ST_POST_B,
        ST_EXP,
        ST_READ,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v < -33'sd2147483648)
            return NEG_INF;
        else if (v > 33'sd2147483647)
            return POS_MAX;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] ladd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        if (a == NEG_INF || b == NEG_INF)
            return NEG_INF;
        return sat33(33'(a) + 33'(b));
    endfunction

    function automatic logic signed [31:0] lsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        if (a == NEG_INF)
            return NEG_INF;
        if (b == NEG_INF)
            return POS_MAX;
        return sat33(33'(a) - 33'(b));
    endfunction

    function automatic logic [15:0] lse_tab(input logic [5:0] k);
        logic [15:0] r;
        case (k)
            6'd0: r = 16'd45426;  6'd1: r = 16'd37745;  6'd2: r = 16'd31069;
            6'd3: r = 16'd25354;  6'd4: r = 16'd20530;  6'd5: r = 16'd16510;
            6'd6: r = 16'd13200;  6'd7: r = 16'd10500;  6'd8: r = 16'd8318;
            6'd9: r = 16'd6567;   6'd10: r = 16'd5170;  6'd11: r = 16'd4061;
            6'd12: r = 16'd3184;  6'd13: r = 16'd2493;  6'd14: r = 16'd1950;
            6'd15: r = 16'd1523;  6'd16: r = 16'd1189;  6'd17: r = 16'd928;
            6'd18: r = 16'd724;   6'd19: r = 16'd565;   6'd20: r = 16'd440;
            6'd21: r = 16'd343;   6'd22: r = 16'd267;   6'd23: r = 16'd208;
            6'd24: r = 16'd162;   6'd25: r = 16'd126;   6'd26: r = 16'd98;
            6'd27: r = 16'd77;    6'd28: r = 16'd60;    6'd29: r = 16'd47;
            6'd30: r = 16'd36;    6'd31: r = 16'd28;    6'd32: r = 16'd22;
            6'd33: r = 16'd17;    6'd34: r = 16'd13;    6'd35: r = 16'd10;
            6'd36: r = 16'd8;     6'd37: r = 16'd6;     6'd38: r = 16'd5;
            6'd39: r = 16'd4;     6'd40: r = 16'd3;     6'd41: r = 16'd2;
            6'd42: r = 16'd2;     6'd43: r = 16'd1;     6'd44: r = 16'd1;
            6'd45: r = 16'd1;     6'd46: r = 16'd1;     6'd47: r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] lse(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic [32:0]        d;
        if (a == NEG_INF)
            return b;
        if (b == NEG_INF)
            return a;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        d  = 33'(33'(hi) - 33'(lo));
        if (d >= 33'(12 << 16))
            return hi;
        return sat33(33'(hi) + 33'($signed({1'b0, lse_tab(d[19:14])})));
    endfunction

    function automatic logic [29:0] exp_tab(input logic [4:0] b);
        logic [29:0] r;
        case (b)
            5'd0: r = 30'd1073725440;  5'd1: r = 30'd1073709056;
            5'd2: r = 30'd1073676290;  5'd3: r = 30'd1073610760;
            5'd4: r = 30'd1073479712;  5'd5: r = 30'd1073217664;
            5'd6: r = 30'd1072693760;  5'd7: r = 30'd1071646719;
            5'd8: r = 30'd1069555701;  5'd9: r = 30'd1065385899;
            5'd10: r = 30'd1057095000; 5'd11: r = 30'd1040706261;
            5'd12: r = 30'd1008687096; 5'd13: r = 30'd947573834;
            5'd14: r = 30'd836230973;  5'd15: r = 30'd651257337;
            5'd16: r = 30'd395007542;  5'd17: r = 30'd145315154;
            5'd18: r = 30'd19666268;   5'd19: r = 30'd360200;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/hmm_forward_backward_posterior.sv -----
// Top level: two-state log-domain HMM, online forward pass, stored backward pass, posteriors.
// A load runs the forward log-sum-exp chain (ST_FWD3 is skipped for the first step of a
// sequence) and the step memory write; both are skipped when the step store is full. A read
// goes through the posterior memory read and the output register. The load marked last also
// runs the backward pass: per step one memory read, four recursion stages and two serial
// exponentials of 20 multiply steps each. Results wait in an output register; no new
// request is taken until the previous result has been taken. The stores need no clearing
// after reset.
module hmm_forward_backward_posterior (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hfbp_pkg::req_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hfbp_pkg::rsp_t       out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = $clog2(hfbp_pkg::MAX_STEPS);
    localparam int CW = AW + 1;

    localparam logic signed [31:0] TAG_NONE = 32'sd0;
    localparam logic signed [31:0] TAG_FWD  = 32'sd1;
    localparam logic signed [31:0] TAG_READ = 32'sd2;

    // memories: per step {alpha, transitions, emissions}, and posteriors
    logic [255:0] step_mem [hfbp_pkg::MAX_STEPS];
    logic [33:0]  post_mem [hfbp_pkg::MAX_STEPS];

    logic [255:0] step_rd;
    logic [63:0]  emis_rd;
    logic [127:0] trans_rd;
    logic [63:0]  alpha_rd;
    logic [33:0]  post_rd;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_fwd;
    logic          wr_post;
    logic [63:0]   wr_emis;
    logic [127:0]  wr_trans;
    logic [63:0]   wr_alpha;
    logic [33:0]   wr_postv;

    always_ff @(posedge clk)
    begin
        if (wr_fwd)
            step_mem[wr_addr] <= {wr_alpha, wr_trans, wr_emis};
        if (wr_post)
            post_mem[wr_addr] <= wr_postv;
        step_rd <= step_mem[rd_addr];
        post_rd <= post_mem[rd_addr];
    end

    assign emis_rd  = step_rd[63:0];
    assign trans_rd = step_rd[191:64];
    assign alpha_rd = step_rd[255:192];

    // config
    logic signed [31:0] init0_reg, init1_reg;
    logic               cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init0_reg <= hfbp_pkg::LN_HALF;
            init1_reg <= hfbp_pkg::LN_HALF;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == hfbp_pkg::REG_INIT0)
                init0_reg <= pwdata;
            else
                init1_reg <= pwdata;
        end
    end

    always_comb
    begin
        case (paddr[2])
            hfbp_pkg::REG_INIT0: prdata = init0_reg;
            default:             prdata = init1_reg;
        endcase
    end

    // control and datapath registers
    hfbp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             done_reg, done_next;
    logic signed [31:0] fphi0_reg, fphi0_next, fphi1_reg, fphi1_next;
    logic signed [31:0] fscale_reg, fscale_next;
    hfbp_pkg::req_t   req_reg, req_next;
    hfbp_pkg::rsp_t   rsp_reg, rsp_next;
    logic             ovalid_reg, ovalid_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic signed [31:0] s_reg, s_next;
    logic signed [31:0] bphi0_reg, bphi0_next, bphi1_reg, bphi1_next;
    logic signed [31:0] beta0_reg, beta0_next, beta1_reg, beta1_next;
    logic signed [31:0] bscale_reg, bscale_next;
    logic [CW-1:0]    t_reg, t_next;
    logic [19:0]      y_reg, y_next;
    logic [30:0]      acc_reg, acc_next;
    logic [4:0]       bit_reg, bit_next;
    logic             ez_reg, ez_next;
    logic             which_reg, which_next;
    logic [16:0]      p0_reg, p0_next;
    logic             err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hfbp_pkg::ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            fphi0_reg  <= '0;
            fphi1_reg  <= '0;
            fscale_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            fphi0_reg  <= fphi0_next;
            fphi1_reg  <= fphi1_next;
            fscale_reg <= fscale_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        s_reg      <= s_next;
        bphi0_reg  <= bphi0_next;
        bphi1_reg  <= bphi1_next;
        beta0_reg  <= beta0_next;
        beta1_reg  <= beta1_next;
        bscale_reg <= bscale_next;
        t_reg      <= t_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        bit_reg    <= bit_next;
        ez_reg     <= ez_next;
        which_reg  <= which_next;
        p0_reg     <= p0_next;
        err_reg    <= err_next;
    end

    assign in_ready  = (state_reg == hfbp_pkg::ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = rsp_reg;

    logic [61:0] prod;
    logic [31:0] pv;
    assign prod = 62'(acc_reg) * 62'(hfbp_pkg::exp_tab(bit_reg));
    assign pv   = (32'(acc_reg) + 32'd8192) >> 14;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        fphi0_next  = fphi0_reg;
        fphi1_next  = fphi1_reg;
        fscale_next = fscale_reg;
        ovalid_next = ovalid_reg;
        req_next    = req_reg;
        rsp_next    = rsp_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        s_next      = s_reg;
        bphi0_next  = bphi0_reg;
        bphi1_next  = bphi1_reg;
        beta0_next  = beta0_reg;
        beta1_next  = beta1_reg;
        bscale_next = bscale_reg;
        t_next      = t_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        bit_next    = bit_reg;
        ez_next     = ez_reg;
        which_next  = which_reg;
        p0_next     = p0_reg;
        err_next    = err_reg;
        rd_addr     = req_reg.read_index[AW-1:0];
        wr_addr     = count_reg[AW-1:0];
        wr_fwd      = 1'b0;
        wr_post     = 1'b0;
        wr_emis     = {req_reg.emit_log_1, req_reg.emit_log_0};
        wr_trans    = {req_reg.trans_log_11, req_reg.trans_log_10,
                       req_reg.trans_log_01, req_reg.trans_log_00};
        wr_alpha    = {hfbp_pkg::ladd(fphi1_reg, fscale_reg),
                       hfbp_pkg::ladd(fphi0_reg, fscale_reg)};
        wr_postv    = {pv[16:0], p0_reg};

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            hfbp_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    req_next = in_data;
                    if (in_data.func == hfbp_pkg::FUNC_READ)
                        state_next = hfbp_pkg::ST_READ;
                    else
                    begin
                        if (done_reg)
                        begin
                            count_next  = '0;
                            fscale_next = '0;
                            done_next   = 1'b0;
                        end
                        state_next = hfbp_pkg::ST_FWD1;
                    end
                end
            end
            hfbp_pkg::ST_FWD1:
            begin
                err_next = (count_reg >= CW'(hfbp_pkg::MAX_STEPS));
                if (count_reg == '0)
                begin
                    a_next = hfbp_pkg::ladd(init0_reg, req_reg.emit_log_0);
                    b_next = hfbp_pkg::ladd(init1_reg, req_reg.emit_log_1);
                    state_next = hfbp_pkg::ST_FWD2;
                end
                else
                begin
                    a_next = hfbp_pkg::lse(hfbp_pkg::ladd(fphi0_reg, req_reg.trans_log_00),
                                           hfbp_pkg::ladd(fphi1_reg, req_reg.trans_log_10));
                    b_next = hfbp_pkg::lse(hfbp_pkg::ladd(fphi0_reg, req_reg.trans_log_01),
                                           hfbp_pkg::ladd(fphi1_reg, req_reg.trans_log_11));
                    state_next = hfbp_pkg::ST_FWD3;
                end
                if (count_reg >= CW'(hfbp_pkg::MAX_STEPS))
                    state_next = req_reg.is_last ? hfbp_pkg::ST_BWD_INIT : hfbp_pkg::ST_OUT;
            end
            hfbp_pkg::ST_FWD3:
            begin
                a_next = hfbp_pkg::ladd(a_reg, req_reg.emit_log_0);
                b_next = hfbp_pkg::ladd(b_reg, req_reg.emit_log_1);
                state_next = hfbp_pkg::ST_FWD2;
            end
            hfbp_pkg::ST_FWD2:
            begin
                s_next = hfbp_pkg::lse(a_reg, b_reg);
                fscale_next = hfbp_pkg::ladd(fscale_reg, s_next);
                fphi0_next = (s_next == hfbp_pkg::NEG_INF) ? hfbp_pkg::NEG_INF
                                                           : hfbp_pkg::lsub(a_reg, s_next);
                fphi1_next = (s_next == hfbp_pkg::NEG_INF) ? hfbp_pkg::NEG_INF
                                                           : hfbp_pkg::lsub(b_reg, s_next);
                state_next = hfbp_pkg::ST_BWD_INIT;
                c_next = TAG_FWD;
            end
            hfbp_pkg::ST_BWD_INIT:
            begin
                // c_reg flags the forward write still pending
                if (!err_reg && c_reg == TAG_FWD)
                begin
                    wr_fwd     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                c_next = TAG_NONE;
                if (!req_reg.is_last)
                    state_next = hfbp_pkg::ST_OUT;
                else
                begin
                    done_next   = 1'b1;
                    bphi0_next  = hfbp_pkg::LN_HALF;
                    bphi1_next  = hfbp_pkg::LN_HALF;
                    beta0_next  = '0;
                    beta1_next  = '0;
                    bscale_next = hfbp_pkg::LN_TWO;
                    t_next      = count_next - 1'b1;
                    state_next  = (count_next == '0) ? hfbp_pkg::ST_OUT
                                                     : hfbp_pkg::ST_POST_A;
                end
            end
            hfbp_pkg::ST_POST_A:
            begin
                // read alpha of step t_reg
                rd_addr    = t_reg[AW-1:0];
                which_next = 1'b0;
                state_next = hfbp_pkg::ST_POST_B;
            end
            hfbp_pkg::ST_POST_B:
            begin
                rd_addr = t_reg[AW-1:0];
                if (which_reg)
                    p0_next = ez_reg ? 17'd0 : pv[16:0];
                a_next = hfbp_pkg::lsub(hfbp_pkg::ladd(which_reg ? alpha_rd[63:32]
                                                                 : alpha_rd[31:0],
                                                       which_reg ? beta1_reg : beta0_reg),
                                        fscale_reg);
                y_next   = 20'(-33'(a_next));
                ez_next  = (a_next == hfbp_pkg::NEG_INF) || (a_next <= -32'sd1048576);
                acc_next = 31'(1 << 30);
                bit_next = '0;
                if (a_next >= 0)
                begin
                    y_next  = '0;
                    ez_next = 1'b0;
                end
                state_next = hfbp_pkg::ST_EXP;
            end
            hfbp_pkg::ST_EXP:
            begin
                rd_addr = t_reg[AW-1:0];
                if (y_reg[0])
                    acc_next = 31'((prod + 62'(1 << 29)) >> 30);
                y_next   = y_reg >> 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 5'd19)
                begin
                    if (!which_reg)
                    begin
                        which_next = 1'b1;
                        state_next = hfbp_pkg::ST_POST_B;
                    end
                    else
                        state_next = hfbp_pkg::ST_BWD_RD;
                end
            end
            hfbp_pkg::ST_BWD_RD:
            begin
                wr_addr  = t_reg[AW-1:0];
                wr_post  = 1'b1;
                wr_postv = {(ez_reg ? 17'd0 : pv[16:0]), p0_reg};
                rd_addr  = t_reg[AW-1:0];
                state_next = (t_reg == '0) ? hfbp_pkg::ST_OUT : hfbp_pkg::ST_BWD_A;
            end
            hfbp_pkg::ST_BWD_A:
            begin
                rd_addr = t_reg[AW-1:0];
                a_next = hfbp_pkg::ladd(bphi0_reg, emis_rd[31:0]);
                b_next = hfbp_pkg::ladd(bphi1_reg, emis_rd[63:32]);
                state_next = hfbp_pkg::ST_BWD_B;
            end
            hfbp_pkg::ST_BWD_B:
            begin
                c_next = hfbp_pkg::lse(hfbp_pkg::ladd(a_reg, trans_rd[31:0]),
                                       hfbp_pkg::ladd(b_reg, trans_rd[63:32]));
                d_next = hfbp_pkg::lse(hfbp_pkg::ladd(a_reg, trans_rd[95:64]),
                                       hfbp_pkg::ladd(b_reg, trans_rd[127:96]));
                state_next = hfbp_pkg::ST_BWD_C;
            end
            hfbp_pkg::ST_BWD_C:
            begin
                beta0_next = hfbp_pkg::ladd(c_reg, bscale_reg);
                beta1_next = hfbp_pkg::ladd(d_reg, bscale_reg);
                s_next     = hfbp_pkg::lse(c_reg, d_reg);
                state_next = hfbp_pkg::ST_BWD_D;
            end
            hfbp_pkg::ST_BWD_D:
            begin
                bphi0_next = (s_reg == hfbp_pkg::NEG_INF) ? hfbp_pkg::NEG_INF
                                                          : hfbp_pkg::lsub(c_reg, s_reg);
                bphi1_next = (s_reg == hfbp_pkg::NEG_INF) ? hfbp_pkg::NEG_INF
                                                          : hfbp_pkg::lsub(d_reg, s_reg);
                bscale_next = hfbp_pkg::ladd(bscale_reg, s_reg);
                t_next      = t_reg - 1'b1;
                state_next  = hfbp_pkg::ST_POST_A;
            end
            hfbp_pkg::ST_READ:
            begin
                err_next = !done_reg || ({1'b0, req_reg.read_index} >= 11'(count_reg))
                           || (32'(req_reg.read_index) >= 32'(hfbp_pkg::MAX_STEPS));
                state_next = hfbp_pkg::ST_OUT;
                c_next = TAG_READ;
            end
            hfbp_pkg::ST_OUT:
            begin
                rsp_next.log_likelihood = fscale_reg;
                rsp_next.status = err_reg;
                rsp_next.post_0 = '0;
                rsp_next.post_1 = '0;
                if (c_reg == TAG_READ && !err_reg)
                begin
                    rsp_next.post_0 = post_rd[16:0];
                    rsp_next.post_1 = post_rd[33:17];
                end
                if (req_reg.func == hfbp_pkg::FUNC_LOAD)
                    rsp_next.status = err_reg;
                c_next      = TAG_NONE;
                ovalid_next = 1'b1;
                state_next  = hfbp_pkg::ST_IDLE;
            end
            default:
                state_next = hfbp_pkg::ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("ready while result pending");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(hfbp_pkg::MAX_STEPS))
        else $error("step count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result before work");
`endif

endmodule
